// File: src/ddo_pkg.sv
// Shared types, widths and constants of the differential drive odometry unit.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

  // Field widths
  localparam int DIST_W  = 32;   // Q15.16 distances, positions and speeds
  localparam int HEAD_W  = 31;   // Q2.28 heading
  localparam int DELTA_W = 33;   // exact difference of two distances
  localparam int DIFF_W  = 34;   // difference of two deltas
  localparam int ANG_W   = 32;   // Q28 working angle
  localparam int CRD_W   = 33;   // Q30 CORDIC x and y
  localparam int MUL_W   = 34;   // shared multiplier operand width
  localparam int PROD_W  = 2 * MUL_W;
  localparam int TICK_W  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int INV_W      = 24;
  localparam int WIN_W      = 16;
  localparam int SCALE_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgInvSpacing = 2'd0,
    CfgVelWindow  = 2'd1,
    CfgVelScale   = 2'd2
  } cfg_idx_e;

  localparam logic [INV_W-1:0]   INV_RESET   = 24'd65536;
  localparam logic [WIN_W-1:0]   WIN_RESET   = 16'd10;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd100;

  // Angle constants in Q28, gain in Q30
  localparam logic signed [ANG_W-1:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 32'sd1686629713;
  localparam logic signed [CRD_W-1:0] GAIN_Q30    = 33'sd652032874;

  // Arctangent table, round(atan(2^-i) * 2^28)
  localparam int TAB_LEN   = 32;
  localparam int TAB_IDX_W = 5;

  typedef logic [TAB_LEN-1:0][ANG_W-1:0] atan_tab_t;

  // Build the table from the alternating arctangent series in Q60
  function automatic atan_tab_t atan_table();
    atan_tab_t   tab;
    longint      sum;
    longint      term;
    int unsigned e;
    tab    = '0;
    tab[0] = 32'd210828714;
    for (int i = 1; i < TAB_LEN; i++) begin
      sum = 0;
      for (int k = 0; k < 64; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          term = longint'((64'd1 << (60 - e)) / 64'(2 * k + 1));
          if ((k & 1) != 0) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      tab[i] = 32'((sum + (64'sd1 <<< 31)) >>> 32);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = atan_table();

  // CORDIC request and response
  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [CRD_W-1:0] cos_v;
    logic signed [CRD_W-1:0] sin_v;
  } cordic_rsp_t;

endpackage

`default_nettype wire

// File: src/ddo_if.sv
// Valid/ready channel interfaces of the odometry unit: tick input, pose result
// and configuration writes. Depends on ddo_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ddo_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ddo_pkg::DIST_W-1:0]   right_distance;
  logic signed [ddo_pkg::DIST_W-1:0]   left_distance;

  modport source (output valid, output right_distance, output left_distance, input ready);
  modport sink (input valid, input right_distance, input left_distance, output ready);
endinterface

interface ddo_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ddo_pkg::DIST_W-1:0]   pos_x;
  logic signed [ddo_pkg::DIST_W-1:0]   pos_y;
  logic signed [ddo_pkg::HEAD_W-1:0]   heading;
  logic signed [ddo_pkg::DIST_W-1:0]   right_speed;
  logic signed [ddo_pkg::DIST_W-1:0]   left_speed;
  logic                                speed_updated;

  modport source (output valid, output pos_x, output pos_y, output heading,
                  output right_speed, output left_speed, output speed_updated,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input heading,
                input right_speed, input left_speed, input speed_updated,
                output ready);
endinterface

interface ddo_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ddo_pkg::CFG_IDX_W-1:0]       index;
  logic [ddo_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/ddo_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ddo_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none

module ddo_mul (
  input  wire                                   clk_i,
  input  wire  logic signed [ddo_pkg::MUL_W-1:0]  a_i,
  input  wire  logic signed [ddo_pkg::MUL_W-1:0]  b_i,
  output logic signed [ddo_pkg::PROD_W-1:0]       p_o
);
  import ddo_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  // Register the full product every cycle
  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: src/ddo_cordic.sv
// Iterative rotation-mode CORDIC: one shift-add step per cycle, cosine and
// sine in Q30 of a Q28 angle. Depends on ddo_pkg for the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module ddo_cordic #(
  parameter int STEPS = 24
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire  ddo_pkg::cordic_req_t  req_i,
  output ddo_pkg::cordic_rsp_t        rsp_o
);
  import ddo_pkg::*;

  localparam logic [TAB_IDX_W-1:0] LastIdx = TAB_IDX_W'(STEPS - 1);

  logic                    busy_q;
  logic                    done_q;
  logic [TAB_IDX_W-1:0]    idx_q;
  logic signed [CRD_W-1:0] x_q, x_d;
  logic signed [CRD_W-1:0] y_q, y_d;
  logic signed [ANG_W-1:0] z_q, z_d;
  logic signed [ANG_W-1:0] atan_v;
  logic signed [CRD_W-1:0] x_sh, y_sh;

  // One micro-rotation, direction from the sign of the residual angle
  always_comb begin
    atan_v = signed'(ATAN_TAB[idx_q]);
    x_sh   = x_q >>> idx_q;
    y_sh   = y_q >>> idx_q;
    if (z_q >= 0) begin
      x_d = x_q - y_sh;
      y_d = y_q + x_sh;
      z_d = z_q - atan_v;
    end else begin
      x_d = x_q + y_sh;
      y_d = y_q - x_sh;
      z_d = z_q + atan_v;
    end
  end

  // Sequence the steps and flag the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load or rotate the working vector
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= GAIN_Q30;
      y_q <= '0;
      z_q <= req_i.z;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = x_q;
  assign rsp_o.sin_v = y_q;

endmodule

`default_nettype wire

// File: src/differential_drive_odometry_unit.sv
// Top level of the differential drive odometry unit: sequencer, pose and speed
// state, configuration registers. Uses ddo_pkg, ddo_if, ddo_mul, ddo_cordic.
//
//   Channel  Dir  Handshake       Payload
//   in_i     in   valid / ready   right_distance, left_distance
//   out_o    out  valid / ready   pos_x, pos_y, heading, right_speed, left_speed,
//                                 speed_updated
//   cfg_i    in   valid / ready   index, data (ready is always high)
//
// An accepted item runs through the sequencer steps StDelta to StPosY, then StMulR, StMulL
// and StSpdL on a tick that refreshes the speeds, and StDone; the next item can be accepted
// once the result is loaded. The sequencer waits in StCordic for the iterative CORDIC; the single shared
// multiplier is used three times, five times on a tick that refreshes the speeds.
// The input is ready only while the sequencer is idle. A result waits in the output
// register, and the next item is taken meanwhile; it stalls only at its own end.
// Reset clears pose, speeds, counters and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_odometry_unit #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  ddo_in_if.sink    in_i,
  ddo_out_if.source out_o,
  ddo_cfg_if.sink   cfg_i
);
  import ddo_pkg::*;

  typedef enum logic [3:0] {
    StIdle,
    StDelta,
    StSums,
    StMulTh,
    StTheta,
    StMid,
    StCordic,
    StMulX,
    StMulY,
    StPosY,
    StMulR,
    StMulL,
    StSpdL,
    StDone
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_accept;
  logic   out_load;

  // Configuration
  logic [INV_W-1:0]   inv_q;
  logic [WIN_W-1:0]   win_q;
  logic [SCALE_W-1:0] scale_q;

  // Architectural state
  logic signed [DIST_W-1:0] prev_r_q, prev_l_q;
  logic signed [DIST_W-1:0] pose_x_q, pose_y_q;
  logic signed [HEAD_W-1:0] heading_q;
  logic signed [DIST_W-1:0] ref_r_q, ref_l_q;
  logic [TICK_W-1:0]        tick_q;
  logic signed [DIST_W-1:0] speed_r_q, speed_l_q;

  // Per-item working registers
  logic signed [DIST_W-1:0]  cur_r_q, cur_l_q;
  logic signed [DELTA_W-1:0] d_r_q, d_l_q, vr_q, vl_q, d_s_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [HEAD_W-1:0]  d_th_q;
  logic signed [CRD_W-1:0]   cos_q, sin_q;
  logic                      neg_q;
  logic                      upd_q;

  // Combinational datapath
  logic [TICK_W-1:0]         tick_inc;
  logic                      upd_d;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  th_sh;
  logic signed [HEAD_W-1:0]  d_th_d;
  logic signed [ANG_W-1:0]   mid;
  logic signed [ANG_W-1:0]   h_sum;
  logic signed [ANG_W-1:0]   h_wrap;
  logic signed [PROD_W-1:0]  pos_sh;
  logic signed [DIST_W+3:0]  pos_sum;
  logic signed [DIST_W-1:0]  pos_sat;
  logic signed [DIST_W-1:0]  spd_sat;
  cordic_req_t               cordic_req;
  cordic_rsp_t               cordic_rsp;

  assign in_i.ready  = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign in_accept   = in_i.valid && in_i.ready;
  assign out_load    = (state_q == StDone) && (!out_valid_q || out_o.ready);

  // Shared units
  ddo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cordic_req),
    .rsp_o  (cordic_rsp)
  );

  // Steer multiplier operands by sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StMulTh: begin
        mul_a = diff_q;
        mul_b = MUL_W'($signed({1'b0, inv_q}));
      end
      StMulX: begin
        mul_a = MUL_W'(d_s_q);
        mul_b = MUL_W'(cos_q);
      end
      StMulY: begin
        mul_a = MUL_W'(d_s_q);
        mul_b = MUL_W'(sin_q);
      end
      StMulR: begin
        mul_a = MUL_W'(vr_q);
        mul_b = MUL_W'($signed({1'b0, scale_q}));
      end
      StMulL: begin
        mul_a = MUL_W'(vl_q);
        mul_b = MUL_W'($signed({1'b0, scale_q}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Window counter
  assign tick_inc = tick_q + 1'b1;
  assign upd_d    = (tick_inc >= win_q);

  // Heading step, saturated to plus or minus pi
  always_comb begin
    th_sh = mul_p >>> 4;
    if (th_sh > PROD_W'(PI_Q28)) begin
      d_th_d = HEAD_W'(PI_Q28);
    end else if (th_sh < -PROD_W'(PI_Q28)) begin
      d_th_d = HEAD_W'(-PI_Q28);
    end else begin
      d_th_d = HEAD_W'(th_sh);
    end
  end

  // Mid-step angle, folded into the CORDIC range, and the wrapped new heading
  always_comb begin
    mid             = ANG_W'(heading_q) + ANG_W'(d_th_q >>> 1);
    cordic_req.start = (state_q == StMid);
    if (mid > HALF_PI_Q28) begin
      cordic_req.z = mid - PI_Q28;
    end else if (mid < -HALF_PI_Q28) begin
      cordic_req.z = mid + PI_Q28;
    end else begin
      cordic_req.z = mid;
    end
    h_sum  = ANG_W'(heading_q) + ANG_W'(d_th_q);
    h_wrap = h_sum;
    if (h_wrap > PI_Q28) begin
      h_wrap = h_wrap - TWO_PI_Q28;
    end
    if (h_wrap < -PI_Q28) begin
      h_wrap = h_wrap + TWO_PI_Q28;
    end
  end

  // Rounded position step plus saturating accumulate; source picked by step; speeds saturate
  always_comb begin
    pos_sh = (mul_p + (PROD_W'(1) <<< 29)) >>> 30;
    if (state_q == StMulY) begin
      pos_sum = (DIST_W + 4)'(pos_sh) + (DIST_W + 4)'(pose_x_q);
    end else begin
      pos_sum = (DIST_W + 4)'(pos_sh) + (DIST_W + 4)'(pose_y_q);
    end
    if (pos_sum > (DIST_W + 4)'(32'sh7fffffff)) begin
      pos_sat = 32'sh7fffffff;
    end else if (pos_sum < (DIST_W + 4)'(-33'sh080000000)) begin
      pos_sat = -32'sh80000000;
    end else begin
      pos_sat = DIST_W'(pos_sum);
    end
    if (mul_p > PROD_W'(32'sh7fffffff)) begin
      spd_sat = 32'sh7fffffff;
    end else if (mul_p < PROD_W'(-33'sh080000000)) begin
      spd_sat = -32'sh80000000;
    end else begin
      spd_sat = DIST_W'(mul_p);
    end
  end

  // Sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      // Raise valid on a load, drop it once the waiting result is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle:   if (in_accept) state_q <= StDelta;
        StDelta:  state_q <= StSums;
        StSums:   state_q <= StMulTh;
        StMulTh:  state_q <= StTheta;
        StTheta:  state_q <= StMid;
        StMid:    state_q <= StCordic;
        StCordic: if (cordic_rsp.done) state_q <= StMulX;
        StMulX:   state_q <= StMulY;
        StMulY:   state_q <= StPosY;
        StPosY:   state_q <= upd_q ? StMulR : StDone;
        StMulR:   state_q <= StMulL;
        StMulL:   state_q <= StSpdL;
        StSpdL:   state_q <= StDone;
        StDone:   if (out_load) state_q <= StIdle;
        default:  state_q <= StIdle;
      endcase
    end
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q   <= INV_RESET;
      win_q   <= WIN_RESET;
      scale_q <= SCALE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CfgInvSpacing: inv_q   <= cfg_i.data[INV_W-1:0];
        CfgVelWindow:  win_q   <= cfg_i.data[WIN_W-1:0];
        CfgVelScale:   scale_q <= cfg_i.data[SCALE_W-1:0];
        default:       inv_q   <= inv_q;
      endcase
    end
  end

  // Pose, reference and speed state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_r_q  <= '0;
      prev_l_q  <= '0;
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
      ref_r_q   <= '0;
      ref_l_q   <= '0;
      tick_q    <= '0;
      speed_r_q <= '0;
      speed_l_q <= '0;
      upd_q     <= 1'b0;
    end else begin
      case (state_q)
        StDelta: begin
          upd_q  <= upd_d;
          tick_q <= upd_d ? '0 : tick_inc;
        end
        StSums: begin
          prev_r_q <= cur_r_q;
          prev_l_q <= cur_l_q;
          if (upd_q) begin
            ref_r_q <= cur_r_q;
            ref_l_q <= cur_l_q;
          end
        end
        StMid:   heading_q <= HEAD_W'(h_wrap);
        StMulY:  pose_x_q  <= pos_sat;
        StPosY:  pose_y_q  <= pos_sat;
        StMulL:  speed_r_q <= spd_sat;
        StSpdL:  speed_l_q <= spd_sat;
        default: upd_q     <= upd_q;
      endcase
    end
  end

  // Per-item working values
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cur_r_q <= in_i.right_distance;
      cur_l_q <= in_i.left_distance;
    end
    if (state_q == StDelta) begin
      d_r_q <= DELTA_W'(cur_r_q) - DELTA_W'(prev_r_q);
      d_l_q <= DELTA_W'(cur_l_q) - DELTA_W'(prev_l_q);
      vr_q  <= DELTA_W'(cur_r_q) - DELTA_W'(ref_r_q);
      vl_q  <= DELTA_W'(cur_l_q) - DELTA_W'(ref_l_q);
    end
    if (state_q == StSums) begin
      d_s_q  <= DELTA_W'((DIFF_W'(d_r_q) + DIFF_W'(d_l_q)) >>> 1);
      diff_q <= DIFF_W'(d_r_q) - DIFF_W'(d_l_q);
    end
    if (state_q == StTheta) begin
      d_th_q <= d_th_d;
    end
    if (state_q == StMid) begin
      neg_q <= (mid > HALF_PI_Q28) || (mid < -HALF_PI_Q28);
    end
    if ((state_q == StCordic) && cordic_rsp.done) begin
      cos_q <= neg_q ? -cordic_rsp.cos_v : cordic_rsp.cos_v;
      sin_q <= neg_q ? -cordic_rsp.sin_v : cordic_rsp.sin_v;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.pos_x         <= pose_x_q;
      out_o.pos_y         <= pose_y_q;
      out_o.heading       <= heading_q;
      out_o.right_speed   <= speed_r_q;
      out_o.left_speed    <= speed_l_q;
      out_o.speed_updated <= upd_q;
    end
  end

  assign out_o.valid = out_valid_q;

  // An accepted item keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_i.ready)
    else $error("input ready right after an accepted item");

  // The CORDIC is never restarted mid-run
  a_cordic_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_req.start |-> !cordic_rsp.busy)
    else $error("CORDIC started while busy");

  // CORDIC completion only while the sequencer waits for it
  a_cordic_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_rsp.done |-> (state_q == StCordic))
    else $error("CORDIC done outside its wait step");

  // Presented heading stays wrapped into plus or minus pi
  a_heading_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((ANG_W'(out_o.heading) <= PI_Q28) &&
                     (ANG_W'(out_o.heading) >= -PI_Q28)))
    else $error("heading outside plus or minus pi");

endmodule

`default_nettype wire
